// ===== hdl/dspe_pkg.sv =====
package dspe_pkg;

  localparam int NUM_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int VERTEX_BITS      = 4;
  localparam int IN_WEIGHT_BITS   = 16;
  localparam int DIST_BITS        = 20;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef enum logic [1:0] {
    SCAN_SEED,
    SCAN_SEL,
    SCAN_RELAX
  } scan_mode_t;

  typedef struct packed {
    logic       load_wr;
    logic       run_start;
    logic       issue;
    scan_mode_t mode;
    logic       mark_visited;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic item_ok;
    logic item_run;
    logic idx_last;
    logic found;
    logic out_space;
  } dp_status_t;

endpackage

// ===== hdl/dspe_ram.sv =====
module dspe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== hdl/dspe_datapath.sv =====
module dspe_datapath #(
  parameter int NUM_VERTICES = dspe_pkg::NUM_VERTICES_DEF,
  parameter int WEIGHT_BITS  = dspe_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_opcode,
  input  logic [dspe_pkg::VERTEX_BITS-1:0]     in_row,
  input  logic [dspe_pkg::VERTEX_BITS-1:0]     in_col,
  input  logic [dspe_pkg::IN_WEIGHT_BITS-1:0]  in_weight,
  input  logic [dspe_pkg::VERTEX_BITS-1:0]     in_start,
  input  dspe_pkg::dp_cmd_t                    cmd,
  output dspe_pkg::dp_status_t                 status,
  input  logic                                 out_tready,
  output logic                                 out_valid,
  output logic [dspe_pkg::VERTEX_BITS-1:0]     out_vertex_id,
  output logic [dspe_pkg::DIST_BITS-1:0]       out_distance,
  output logic                                 out_reachable,
  output logic                                 out_last
);

  localparam int VW   = $clog2(NUM_VERTICES);
  localparam int AW   = 2 * VW;
  localparam int DB   = dspe_pkg::DIST_BITS;
  localparam int SUMW = ((DB > WEIGHT_BITS) ? DB : WEIGHT_BITS) + 1;

  function automatic logic [DB-1:0] sat_add(input logic [DB-1:0] d,
                                            input logic [WEIGHT_BITS-1:0] w);
    logic [SUMW-1:0] s;
    s = SUMW'(d) + SUMW'(w);
    return (s > SUMW'(dspe_pkg::DIST_MAX)) ? dspe_pkg::DIST_MAX : DB'(s);
  endfunction

  logic [VW-1:0]           row_idx, col_idx;
  logic [VW-1:0]           st_r, idx_r, idx_nxt, p_idx_r, u_r;
  logic                    idx_last;
  logic                    p_vld_r;
  dspe_pkg::scan_mode_t    p_mode_r;
  logic [NUM_VERTICES-1:0] visited_r, reach_r;
  logic                    found_r;
  logic [DB-1:0]           du_r;
  logic                    out_valid_r, out_reachable_r, out_last_r;
  logic [dspe_pkg::VERTEX_BITS-1:0] out_vertex_id_r;
  logic [DB-1:0]           out_distance_r;

  logic [AW-1:0]           w_raddr;
  logic [WEIGHT_BITS-1:0]  w_rd;
  logic [DB-1:0]           d_rd, d_wd, sum;
  logic                    d_we;
  logic                    no_edge, p_unvis, p_reach, p_is_start;
  logic                    found_eff, cand, take;
  logic                    seed_wr, relax_wr, seed_reach;

  assign row_idx  = VW'(in_row);
  assign col_idx  = VW'(in_col);
  assign idx_last = (idx_r == VW'(NUM_VERTICES - 1));
  assign idx_nxt  = idx_last ? '0 : idx_r + 1'b1;

  assign status.item_run  = (in_opcode == dspe_pkg::OP_RUN);
  assign status.item_ok   = status.item_run ? (32'(in_start) < NUM_VERTICES)
                          : ((32'(in_row) < NUM_VERTICES) && (32'(in_col) < NUM_VERTICES));
  assign status.idx_last  = idx_last;
  assign status.found     = found_r;
  assign status.out_space = !out_valid_r || out_tready;

  assign w_raddr = {(cmd.mode == dspe_pkg::SCAN_RELAX) ? u_r : st_r, idx_r};

  dspe_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(1 << AW)) u_weight_ram (
    .clk   (clk),
    .we    (cmd.load_wr),
    .waddr ({row_idx, col_idx}),
    .wdata (WEIGHT_BITS'(in_weight)),
    .raddr (w_raddr),
    .rdata (w_rd)
  );

  dspe_ram #(.WIDTH(DB), .DEPTH(NUM_VERTICES)) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (p_idx_r),
    .wdata (d_wd),
    .raddr (idx_r),
    .rdata (d_rd)
  );

  always_comb begin
    no_edge    = (w_rd == '1);
    p_unvis    = !visited_r[p_idx_r];
    p_reach    = reach_r[p_idx_r];
    p_is_start = (p_idx_r == st_r);
    sum        = sat_add((p_mode_r == dspe_pkg::SCAN_SEED) ? '0 : du_r, w_rd);
    found_eff  = found_r && (p_idx_r != '0);
    cand       = p_unvis && p_reach;
    take       = p_vld_r && (p_mode_r == dspe_pkg::SCAN_SEL) && cand &&
                 (!found_eff || (d_rd < du_r));
    seed_wr    = p_vld_r && (p_mode_r == dspe_pkg::SCAN_SEED);
    seed_reach = p_is_start || !no_edge;
    relax_wr   = p_vld_r && (p_mode_r == dspe_pkg::SCAN_RELAX) && p_unvis && !no_edge &&
                 (!p_reach || (sum < d_rd));
    d_we       = seed_wr || relax_wr;
    d_wd       = (seed_wr && (p_is_start || no_edge)) ? '0 : sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      p_vld_r     <= 1'b0;
      visited_r   <= '0;
      reach_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_vld_r <= cmd.issue;
      if (cmd.issue || cmd.out_load) begin
        idx_r <= idx_nxt;
      end
      if (cmd.run_start) begin
        visited_r <= {{(NUM_VERTICES-1){1'b0}}, 1'b1} << VW'(in_start);
      end else if (cmd.mark_visited) begin
        visited_r[u_r] <= 1'b1;
      end
      if (seed_wr) begin
        reach_r[p_idx_r] <= seed_reach;
      end else if (relax_wr) begin
        reach_r[p_idx_r] <= 1'b1;
      end
      if (p_vld_r && (p_mode_r == dspe_pkg::SCAN_SEL)) begin
        found_r <= found_eff || cand;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r  <= idx_r;
    p_mode_r <= cmd.mode;
    if (cmd.run_start) begin
      st_r <= VW'(in_start);
    end
    if (take) begin
      u_r  <= p_idx_r;
      du_r <= d_rd;
    end
    if (cmd.out_load) begin
      out_vertex_id_r <= dspe_pkg::VERTEX_BITS'(idx_r);
      out_distance_r  <= reach_r[idx_r] ? d_rd : dspe_pkg::DIST_MAX;
      out_reachable_r <= reach_r[idx_r];
      out_last_r      <= idx_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_vertex_id = out_vertex_id_r;
  assign out_distance  = out_distance_r;
  assign out_reachable = out_reachable_r;
  assign out_last      = out_last_r;

  a_select_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_visited |-> (!visited_r[u_r] && reach_r[u_r]))
    else $error("selected vertex is visited or unreachable");

  a_start_visited: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> visited_r[st_r])
    else $error("start vertex not marked visited during a run");

  a_no_load_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_wr |-> !p_vld_r)
    else $error("weight write while a scan is in flight");

endmodule

// ===== hdl/dspe_ctrl.sv =====
module dspe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  dspe_pkg::dp_status_t status,
  output dspe_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_SEL,
    ST_SEL_T,
    ST_SEL_CHK,
    ST_RELAX,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && status.item_ok) begin
          if (status.item_run) begin
            cmd.run_start = 1'b1;
            state_nxt     = ST_SEED;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_SEED: begin
        cmd.issue = 1'b1;
        cmd.mode  = dspe_pkg::SCAN_SEED;
        if (status.idx_last) begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        cmd.issue = 1'b1;
        cmd.mode  = dspe_pkg::SCAN_SEL;
        if (status.idx_last) begin
          state_nxt = ST_SEL_T;
        end
      end
      ST_SEL_T: begin
        state_nxt = ST_SEL_CHK;
      end
      ST_SEL_CHK: begin
        if (status.found) begin
          cmd.mark_visited = 1'b1;
          state_nxt        = ST_RELAX;
        end else begin
          state_nxt = ST_OUT_RD;
        end
      end
      ST_RELAX: begin
        cmd.issue = 1'b1;
        cmd.mode  = dspe_pkg::SCAN_RELAX;
        if (status.idx_last) begin
          state_nxt = ST_SEL;
        end
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (status.out_space) begin
          cmd.out_load = 1'b1;
          state_nxt    = status.idx_last ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_ready_after_output: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_tready) |-> $past(cmd.out_load))
    else $error("returned to idle without emitting the last result");

  a_idle_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!cmd.issue && !cmd.out_load && !cmd.mark_visited))
    else $error("scan activity while accepting input");

endmodule

// ===== hdl/dense_shortest_path_engine_unit.sv =====
// A run from start, with N vertices and R vertices selected (R < N), does a seed scan, then R
// select and relax scan pairs, a last select scan that finds no vertex, and N result reads,
// each scan stepping the single read port of the weight and distance memories one entry a cycle.
// One item is worked on at a time; the next item is taken once the last result is registered.
// Reset: synchronous active-low rst_n clears the controller, marks and output valid;
// the weight matrix holds no defined value until written.
module dense_shortest_path_engine_unit #(
  parameter int NUM_VERTICES = dspe_pkg::NUM_VERTICES_DEF,
  parameter int WEIGHT_BITS  = dspe_pkg::WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // row_vertex, col_vertex, edge_weight, start_vertex
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // vertex_id, distance
  output logic        out_tuser,  // reachable
  output logic        out_tlast   // last_result
);

  dspe_pkg::dp_cmd_t    cmd;
  dspe_pkg::dp_status_t status;

  logic [dspe_pkg::VERTEX_BITS-1:0] out_vertex_id;
  logic [dspe_pkg::DIST_BITS-1:0]   out_distance;

  dspe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  dspe_datapath #(
    .NUM_VERTICES (NUM_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_opcode     (in_tuser),
    .in_row        (in_tdata[3:0]),
    .in_col        (in_tdata[7:4]),
    .in_weight     (in_tdata[23:8]),
    .in_start      (in_tdata[27:24]),
    .cmd           (cmd),
    .status        (status),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .out_vertex_id (out_vertex_id),
    .out_distance  (out_distance),
    .out_reachable (out_tuser),
    .out_last      (out_tlast)
  );

  assign out_tdata = {out_distance, out_vertex_id};

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

  localparam int VERTS = dspe_pkg::NUM_VERTICES_DEF;
  localparam int VB    = dspe_pkg::VERTEX_BITS;
  localparam int WB    = dspe_pkg::IN_WEIGHT_BITS;
  localparam int DB    = dspe_pkg::DIST_BITS;
  localparam logic [WB-1:0] NO_EDGE  = '1;
  localparam logic [DB-1:0] DIST_MAX = dspe_pkg::DIST_MAX;

  typedef struct {
    logic [VB-1:0] vertex;
    logic [DB-1:0] cost;
    logic          reach;
    logic          last;
  } path_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  logic [WB-1:0] edge_cost [VERTS][VERTS];
  path_result_t  pending_distances [$];
  int            failures;
  bit            src_idle_en;
  bit            sink_idle_en;
  int            sink_hold;

  dense_shortest_path_engine_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [DB-1:0] sat_sum(logic [DB-1:0] d, logic [WB-1:0] w);
    int unsigned s;
    s = int'(d) + int'(w);
    if (s > int'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return s[DB-1:0];
  endfunction

  function automatic void predict_distances(logic [VB-1:0] src);
    logic [DB-1:0] best [VERTS];
    bit            reach [VERTS];
    bit            done [VERTS];
    bit            found;
    int            u;
    logic [DB-1:0] s;
    path_result_t  r;
    for (int i = 0; i < VERTS; i++) begin
      done[i] = 0;
      if (edge_cost[src][i] != NO_EDGE) begin
        reach[i] = 1;
        best[i] = sat_sum('0, edge_cost[src][i]);
      end else begin
        reach[i] = 0;
        best[i] = '0;
      end
    end
    done[src] = 1;
    reach[src] = 1;
    best[src] = '0;
    for (int k = 0; k < VERTS - 1; k++) begin
      found = 0;
      u = 0;
      for (int i = 0; i < VERTS; i++) begin
        if (!done[i] && reach[i] && (!found || best[i] < best[u])) begin
          found = 1;
          u = i;
        end
      end
      if (!found) begin
        break;
      end
      done[u] = 1;
      for (int j = 0; j < VERTS; j++) begin
        if (!done[j] && edge_cost[u][j] != NO_EDGE) begin
          s = sat_sum(best[u], edge_cost[u][j]);
          if (!reach[j] || s < best[j]) begin
            reach[j] = 1;
            best[j] = s;
          end
        end
      end
    end
    for (int i = 0; i < VERTS; i++) begin
      r.vertex = i[VB-1:0];
      r.cost = reach[i] ? best[i] : DIST_MAX;
      r.reach = reach[i];
      r.last = (i == VERTS - 1);
      pending_distances.push_back(r);
    end
  endfunction

  // Starts and ends at a falling edge; valid stays high between back-to-back beats.
  task automatic drive_item(logic op, logic [VB-1:0] row, logic [VB-1:0] col,
                            logic [WB-1:0] weight, logic [VB-1:0] start);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0, start, weight, col, row};
    forever begin
      @(posedge clk);
      if (in_tready) begin
        break;
      end
    end
    if (op == dspe_pkg::OP_LOAD) begin
      edge_cost[row][col] = weight;
    end else begin
      predict_distances(start);
    end
    @(negedge clk);
  endtask

  task automatic load_edge(int row, int col, logic [WB-1:0] weight);
    drive_item(dspe_pkg::OP_LOAD, row[VB-1:0], col[VB-1:0], weight,
               VB'($urandom_range(0, VERTS - 1)));
  endtask

  task automatic run_from(int start);
    drive_item(dspe_pkg::OP_RUN, VB'($urandom_range(0, VERTS - 1)),
               VB'($urandom_range(0, VERTS - 1)), WB'($urandom), start[VB-1:0]);
  endtask

  // Runs only touch vertices 0 to 5 and the last one, whose rows are all written.
  function automatic int pick_vertex();
    int sel;
    sel = $urandom_range(0, 6);
    return (sel == 6) ? VERTS - 1 : sel;
  endfunction

  function automatic logic [WB-1:0] pick_weight(int edge_pct);
    int sel;
    if ($urandom_range(99) >= edge_pct) begin
      return NO_EDGE;
    end
    sel = $urandom_range(9);
    case (sel)
      0: begin
        return '0;
      end
      1: begin
        return NO_EDGE - 16'd1;
      end
      2, 3, 4, 5: begin
        return WB'($urandom_range(1, 20));
      end
      default: begin
        return WB'($urandom);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    path_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_distances.size() == 0) begin
        $error("Unexpected result beat: vertex_id %0d", out_tdata[3:0]);
        failures++;
      end else begin
        exp_r = pending_distances.pop_front();
        if (out_tdata[3:0] !== exp_r.vertex) begin
          $error("vertex_id mismatch: expected %0d, actual %0d", exp_r.vertex,
                 out_tdata[3:0]);
          failures++;
        end
        if (out_tdata[23:4] !== exp_r.cost) begin
          $error("distance mismatch: expected %0d, actual %0d", exp_r.cost,
                 out_tdata[23:4]);
          failures++;
        end
        if (out_tuser !== exp_r.reach) begin
          $error("reachable mismatch: expected %0d, actual %0d", exp_r.reach, out_tuser);
          failures++;
        end
        if (out_tlast !== exp_r.last) begin
          $error("last_result mismatch: expected %0d, actual %0d", exp_r.last, out_tlast);
          failures++;
        end
      end
      sink_hold = sink_idle_en ? $urandom_range(0, 11) : 0;
    end
  end

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic test_clear_rows();
    int r;
    src_idle_en = 0;
    sink_idle_en = 0;
    for (int n = 0; n < 7; n++) begin
      r = (n == 6) ? VERTS - 1 : n;
      for (int c = 0; c < VERTS; c++) begin
        load_edge(r, c, NO_EDGE);
      end
    end
  endtask

  task automatic test_isolated_starts();
    run_from(0);
    run_from(VERTS - 1);
  endtask

  task automatic test_self_loop();
    src_idle_en = 1;
    sink_idle_en = 1;
    load_edge(3, 3, 16'd5);
    run_from(3);
  endtask

  task automatic test_edge_extremes();
    load_edge(0, 1, '0);
    load_edge(1, 2, NO_EDGE - 16'd1);
    load_edge(2, 15, 16'd1);
    load_edge(15, 0, 16'd7);
    load_edge(0, 2, 16'h8000);
    run_from(0);
    run_from(15);
  endtask

  task automatic test_tie_break();
    src_idle_en = 0;
    load_edge(4, 5, 16'd10);
    load_edge(4, 3, 16'd10);
    load_edge(3, 2, 16'd5);
    load_edge(5, 2, 16'd5);
    run_from(4);
  endtask

  task automatic test_random_updates();
    for (int round = 0; round < 3; round++) begin
      src_idle_en = (round % 3) != 1;
      sink_idle_en = (round % 3) != 2;
      for (int n = 0; n < 6; n++) begin
        load_edge(pick_vertex(), pick_vertex(), pick_weight(70));
      end
      run_from(pick_vertex());
    end
  endtask

  initial begin
    int wait_cycles;
    failures = 0;
    sink_hold = 0;
    src_idle_en = 0;
    sink_idle_en = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = dspe_pkg::OP_LOAD;
    out_tready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_clear_rows();
    test_isolated_starts();
    test_self_loop();
    test_edge_extremes();
    test_tie_break();
    test_random_updates();

    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending_distances.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (64) @(posedge clk);
    if (pending_distances.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_distances.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
